FILE: design/spadj_pkg.sv
`default_nettype none
package spadj_pkg;

	localparam int DIST_W = 21;
	localparam int OUT_DIST_W = 20;
	localparam int IN_W = 16;
	localparam int VTX_PORT_W = 4;

	localparam logic [DIST_W-1:0] DIST_INF = '1;
	localparam logic [DIST_W-1:0] DIST_MAX = 21'h0F_FFFF;
	localparam logic [OUT_DIST_W-1:0] DIST_OUT_MAX = '1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// caller keeps d at or below DIST_MAX, so the sum fits in DIST_W bits
	function automatic logic [DIST_W-1:0] sat_add(
		input logic [DIST_W-1:0] d,
		input logic [IN_W-1:0] w
	);
		logic [DIST_W-1:0] s;
		s = d + DIST_W'(w);
		return (s > DIST_MAX) ? DIST_MAX : s;
	endfunction

endpackage
`default_nettype wire

FILE: design/spadj_edge_ram.sv
`default_nettype none
module spadj_edge_ram #(
	parameter int NUM_VERTICES = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] wr_row,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] wr_col,
	input  logic [spadj_pkg::IN_W-1:0] wr_weight,
	input  logic rd_en,
	input  logic [$clog2(NUM_VERTICES)-1:0] rd_row,
	input  logic [$clog2(NUM_VERTICES)-1:0] rd_col,
	output logic [((WEIGHT_BITS < spadj_pkg::IN_W) ? WEIGHT_BITS : spadj_pkg::IN_W)-1:0] rd_weight,
	output logic busy
);
	import spadj_pkg::*;

	localparam int VW = $clog2(NUM_VERTICES);
	localparam int SW = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;
	localparam int AW = 2 * VW;
	localparam int DEPTH = 1 << AW;

	logic [SW-1:0] mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic busy_q;
	logic in_range;
	logic [AW-1:0] wr_addr;

	assign in_range = (32'(wr_row) < NUM_VERTICES) && (32'(wr_col) < NUM_VERTICES);
	assign wr_addr = {VW'(wr_row), VW'(wr_col)};
	assign busy = busy_q;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (&clr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en && in_range) begin
			mem[wr_addr] <= SW'(wr_weight);
		end
		if (rd_en) begin
			rd_weight <= mem[{rd_row, rd_col}];
		end
	end

endmodule
`default_nettype wire

FILE: design/shortest_path_adjacency_matrix_top.sv
`default_nettype none
// channel  direction  handshake            fields
// req      in         req_valid/req_stall  cmd row col weight start_vertex end_vertex
// rsp      out        rsp_valid/rsp_stall  path_vertex distance reachable last
//
// a write beat stores one edge weight; a query runs a setup sweep over the vertices, then N-1
// relaxation passes over the vertex memory, then walks predecessors and emits one
// result beat per path vertex
// after reset all 2^(2*clog2(N)) entries of the edge memory are swept to zero with req stalled
// results leave through an output register; rsp_stall holds it, and the next request is
// taken once the final beat of a query sits in that register
module shortest_path_adjacency_matrix_top #(
	parameter int NUM_VERTICES = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic [0:0] cmd,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] row,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] col,
	input  logic [spadj_pkg::IN_W-1:0] weight,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] start_vertex,
	input  logic [spadj_pkg::VTX_PORT_W-1:0] end_vertex,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [spadj_pkg::VTX_PORT_W-1:0] path_vertex,
	output logic [spadj_pkg::OUT_DIST_W-1:0] distance,
	output logic reachable,
	output logic last
);
	import spadj_pkg::*;

	localparam int VW = $clog2(NUM_VERTICES);
	localparam int SW = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;
	localparam int CW = $clog2(NUM_VERTICES + 1);
	localparam int VDEPTH = 1 << VW;
	localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VERTICES - 1);
	localparam logic [VW-1:0] LAST_ROUND = VW'(NUM_VERTICES - 2);
	localparam logic [CW-1:0] CNT_END = CW'(NUM_VERTICES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_PASS = 3'd2;
	localparam logic [2:0] ST_WALK_RD = 3'd3;
	localparam logic [2:0] ST_WALK_CHK = 3'd4;
	localparam logic [2:0] ST_EMIT_RD = 3'd5;
	localparam logic [2:0] ST_EMIT_LD = 3'd6;
	localparam logic [2:0] ST_UNREACH = 3'd7;

	typedef struct packed {
		logic done;
		logic pvalid;
		logic [VW-1:0] prev;
		logic [DIST_W-1:0] cost;
	} vent_t;

	vent_t vmem [VDEPTH];
	logic [VW-1:0] pmem [VDEPTH];

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] round_q;
	logic [VW-1:0] u_q;
	logic [DIST_W-1:0] best_q;
	logic [VW-1:0] nu_q;
	logic [DIST_W-1:0] nbest_q;
	logic [VW-1:0] s_q;
	logic [VTX_PORT_W-1:0] e_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] n_q;
	logic [VW-1:0] p_q;
	logic [OUT_DIST_W-1:0] dist_e_q;
	logic [VW-1:0] prd_q;

	logic vld_s1;
	logic [VW-1:0] idx_s1;
	vent_t vrd_s1;
	logic [SW-1:0] wrd_s1;
	logic vld_s2;
	logic [VW-1:0] idx_s2;
	vent_t ent_s2;

	logic rsp_valid_q;
	logic [VTX_PORT_W-1:0] path_vertex_q;
	logic [OUT_DIST_W-1:0] distance_q;
	logic reachable_q;
	logic last_q;

	logic edge_busy;
	logic req_acc;
	logic rsp_acc;
	logic rsp_free;
	logic rsp_load;
	logic pass_issue;
	logic pass_end;
	logic vm_we;
	logic [VW-1:0] vm_wa;
	vent_t vm_wd;
	logic vm_re;
	logic [VW-1:0] vm_ra;
	logic pm_we;
	logic pm_re;
	logic walk_miss;
	logic [DIST_W-1:0] nd;
	vent_t new_ent;

	assign req_stall = (state_q != ST_IDLE) || edge_busy;
	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid_q && !rsp_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = ((state_q == ST_EMIT_LD) || (state_q == ST_UNREACH)) && rsp_free;

	assign pass_issue = (state_q == ST_PASS) && (cnt_q != CNT_END);
	assign pass_end = (state_q == ST_PASS) && (cnt_q == CNT_END) && !vld_s1 && !vld_s2;
	assign walk_miss = (n_q == '0) && (vrd_s1.cost == DIST_INF);

	assign rsp_valid = rsp_valid_q;
	assign path_vertex = path_vertex_q;
	assign distance = distance_q;
	assign reachable = reachable_q;
	assign last = last_q;

	spadj_edge_ram #(
		.NUM_VERTICES(NUM_VERTICES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_edge_ram (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(req_acc && (cmd == CMD_WRITE)),
		.wr_row(row),
		.wr_col(col),
		.wr_weight(weight),
		.rd_en(pass_issue),
		.rd_row(u_q),
		.rd_col(cnt_q[VW-1:0]),
		.rd_weight(wrd_s1),
		.busy(edge_busy)
	);

	// relaxation of one neighbor
	always_comb begin
		nd = sat_add(best_q, IN_W'(wrd_s1));
		new_ent = vrd_s1;
		if (idx_s1 == u_q) begin
			new_ent.done = 1'b1;
		end else if (!vrd_s1.done && (wrd_s1 != '0) && (best_q != DIST_INF)
				&& (nd < vrd_s1.cost)) begin
			new_ent.cost = nd;
			new_ent.prev = u_q;
			new_ent.pvalid = 1'b1;
		end
	end

	always_comb begin
		vm_we = 1'b0;
		vm_wa = idx_s1;
		vm_wd = new_ent;
		vm_re = 1'b0;
		vm_ra = cnt_q[VW-1:0];
		if (state_q == ST_INIT) begin
			vm_we = 1'b1;
			vm_wa = cnt_q[VW-1:0];
			vm_wd = '0;
			vm_wd.cost = (cnt_q[VW-1:0] == s_q) ? '0 : DIST_INF;
		end else if (vld_s1) begin
			vm_we = 1'b1;
		end
		if (pass_issue) begin
			vm_re = 1'b1;
		end else if (state_q == ST_WALK_RD) begin
			vm_re = 1'b1;
			vm_ra = v_q;
		end
	end

	assign pm_we = (state_q == ST_WALK_CHK) && !walk_miss;
	assign pm_re = (state_q == ST_EMIT_RD);

	always_ff @(posedge clk) begin
		if (vm_we) begin
			vmem[vm_wa] <= vm_wd;
		end
		if (vm_re) begin
			vrd_s1 <= vmem[vm_ra];
		end
		if (pm_we) begin
			pmem[n_q] <= v_q;
		end
		if (pm_re) begin
			prd_q <= pmem[p_q];
		end
		idx_s1 <= cnt_q[VW-1:0];
		idx_s2 <= idx_s1;
		ent_s2 <= new_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			round_q <= '0;
			u_q <= '0;
			best_q <= '0;
			nu_q <= '0;
			nbest_q <= DIST_INF;
			s_q <= '0;
			e_q <= '0;
			v_q <= '0;
			n_q <= '0;
			p_q <= '0;
			dist_e_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			rsp_valid_q <= 1'b0;
			path_vertex_q <= '0;
			distance_q <= '0;
			reachable_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			vld_s1 <= pass_issue;
			vld_s2 <= vld_s1;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (cmd == CMD_QUERY)) begin
						s_q <= VW'(start_vertex);
						e_q <= end_vertex;
						cnt_q <= '0;
						if ((32'(start_vertex) >= NUM_VERTICES)
								|| (32'(end_vertex) >= NUM_VERTICES)) begin
							state_q <= ST_UNREACH;
						end else begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (cnt_q[VW-1:0] == LAST_IDX) begin
						cnt_q <= '0;
						round_q <= '0;
						u_q <= s_q;
						best_q <= '0;
						nu_q <= '0;
						nbest_q <= DIST_INF;
						state_q <= ST_PASS;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_PASS: begin
					if (pass_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					// next vertex: lowest distance, highest index on ties
					if (vld_s2 && !ent_s2.done && (ent_s2.cost <= nbest_q)) begin
						nbest_q <= ent_s2.cost;
						nu_q <= idx_s2;
					end
					if (pass_end) begin
						cnt_q <= '0;
						u_q <= nu_q;
						best_q <= nbest_q;
						nu_q <= '0;
						nbest_q <= DIST_INF;
						round_q <= round_q + VW'(1);
						if (round_q == LAST_ROUND) begin
							v_q <= VW'(e_q);
							n_q <= '0;
							state_q <= ST_WALK_RD;
						end
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_CHK;
				end
				ST_WALK_CHK: begin
					if (walk_miss) begin
						state_q <= ST_UNREACH;
					end else begin
						if (n_q == '0) begin
							dist_e_q <= vrd_s1.cost[OUT_DIST_W-1:0];
						end
						if (!vrd_s1.pvalid || (n_q == LAST_IDX)) begin
							p_q <= n_q;
							state_q <= ST_EMIT_RD;
						end else begin
							n_q <= n_q + VW'(1);
							v_q <= vrd_s1.prev;
							state_q <= ST_WALK_RD;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (rsp_free) begin
						path_vertex_q <= VTX_PORT_W'(prd_q);
						distance_q <= dist_e_q;
						reachable_q <= 1'b1;
						last_q <= (p_q == '0);
						if (p_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							p_q <= p_q - VW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_UNREACH: begin
					if (rsp_free) begin
						path_vertex_q <= e_q;
						distance_q <= DIST_OUT_MAX;
						reachable_q <= 1'b0;
						last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
